// ===== design/dc_blocking_biquad_cascade_unit_macros.svh =====
// assertion macros for the dc blocking biquad cascade
`ifndef DC_BLOCKING_BIQUAD_CASCADE_UNIT_MACROS_SVH
`define DC_BLOCKING_BIQUAD_CASCADE_UNIT_MACROS_SVH

// same-cycle implication
`define DCBQ_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define DCBQ_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== design/dcbq_pkg.sv =====
package dcbq_pkg;

  localparam int SECTIONS = 3;
  localparam int SAMPLE_W = 24;
  localparam int HIST_W   = 40;
  localparam int ACC_W    = 45;
  localparam int COEF_W   = 32;
  localparam int LO_W     = 20;
  localparam int MUL_W    = COEF_W + LO_W + 1;
  localparam int FULL_W   = MUL_W + LO_W;
  localparam int DEPTH    = 4 * SECTIONS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  localparam int SEC_SHIFT  = 30;
  localparam int GAIN_SHIFT = 38;

  // history slots within a section
  localparam logic [1:0] TERM_X1 = 2'd0;
  localparam logic [1:0] TERM_X2 = 2'd1;
  localparam logic [1:0] TERM_Y1 = 2'd2;
  localparam logic [1:0] TERM_Y2 = 2'd3;

  localparam logic signed [COEF_W-1:0] GAIN_Q30 = 32'sd1467718208;
  localparam logic signed [HIST_W-1:0] FLUSH_LIM = 40'sd215;
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic mul_lo;
    logic mul_hi;
    logic gain;
  } mac_ctl_t;

  // coefficient for one history slot of one section, Q2.30
  function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [1:0] sec,
                                                           input logic [1:0] term);
    logic signed [COEF_W-1:0] c;
    case ({sec, term})
      {2'd0, TERM_X1}: c = -32'sd2147483219;
      {2'd0, TERM_X2}: c =  32'sd1073741824;
      {2'd0, TERM_Y1}: c = -32'sd2147236151;
      {2'd0, TERM_Y2}: c =  32'sd1073498664;
      {2'd1, TERM_X1}: c = -32'sd2147483433;
      {2'd1, TERM_X2}: c =  32'sd1073741824;
      {2'd1, TERM_Y1}: c = -32'sd2145874109;
      {2'd1, TERM_Y2}: c =  32'sd1072142808;
      {2'd2, TERM_X1}: c = -32'sd1073741824;
      {2'd2, TERM_Y1}: c = -32'sd1062777610;
      default:         c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/dcbq_hist_ram.sv =====
module dcbq_hist_ram
  import dcbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [HIST_W-1:0] wr_data,
  output logic signed [HIST_W-1:0] rd_data
);

  logic signed [HIST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld;
  logic signed [HIST_W-1:0] rd_q;
  logic                     rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== design/dcbq_mac.sv =====
module dcbq_mac
  import dcbq_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [HIST_W-1:0] h,
  output logic signed [ACC_W-1:0]  rounded
);

  logic signed [LO_W:0]       mul_b;
  logic signed [MUL_W-1:0]    prod;
  logic signed [MUL_W-1:0]    p_lo;
  logic signed [MUL_W-1:0]    p_hi;
  logic signed [FULL_W-1:0]   rnd;
  logic signed [FULL_W-1:0]   full;
  logic signed [FULL_W-1:0]   shifted;

  // low half unsigned, high half signed
  always_comb begin
    if (ctl.mul_hi) begin
      mul_b = $signed({h[HIST_W-1], h[HIST_W-1:LO_W]});
    end else begin
      mul_b = $signed({1'b0, h[LO_W-1:0]});
    end
    prod = coef * mul_b;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_lo) begin
      p_lo <= prod;
    end
    if (ctl.mul_hi) begin
      p_hi <= prod;
    end
  end

  // round half up, then floor shift
  always_comb begin
    if (ctl.gain) begin
      rnd = FULL_W'(1) <<< (GAIN_SHIFT - 1);
    end else begin
      rnd = FULL_W'(1) <<< (SEC_SHIFT - 1);
    end
    full = (FULL_W'(p_hi) <<< LO_W) + FULL_W'(p_lo) + rnd;
    if (ctl.gain) begin
      shifted = full >>> GAIN_SHIFT;
    end else begin
      shifted = full >>> SEC_SHIFT;
    end
    rounded = ACC_W'(shifted);
  end

endmodule

// ===== design/dc_blocking_biquad_cascade_unit.sv =====
// a new input word is accepted only while the sequencer is idle, so the next word waits until
//   the current one has reached the output register; the pace is set by the single shared
//   multiplier doing two half products per history term and by the history memory sequence
// a finished word waits in the output register while the next input word is processed
// reset: synchronous active-high rst clears the sequencer, the output valid and the
//   history valid bits, so all section history reads as zero after reset
`include "dc_blocking_biquad_cascade_unit_macros.svh"

module dc_blocking_biquad_cascade_unit
  import dcbq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       dst_valid,
  input  logic                       dst_ready,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_MLO  = 4'd3;
  localparam logic [3:0] S_MHI  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_SAT  = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_GAIN = 4'd8;

  logic [3:0]               state;
  logic [SEC_W-1:0]         sec;
  logic [1:0]               term;
  logic [1:0]               wcnt;
  logic                     gain_ph;

  // datapath registers
  logic signed [HIST_W-1:0] x_cur;     // input of the current section
  logic signed [ACC_W-1:0]  acc;       // section sum
  logic signed [HIST_W-1:0] y_val;     // saturated section output
  logic signed [HIST_W-1:0] x1_save;
  logic signed [HIST_W-1:0] y1_save;
  logic signed [HIST_W-1:0] h_reg;     // multiplier operand

  logic                     src_acc;
  logic                     out_load;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [HIST_W-1:0] wr_data;
  logic signed [HIST_W-1:0] rd_data;
  logic [1:0]               wterm;
  mac_ctl_t                 mac_ctl;
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [HIST_W-1:0] x_scaled;

  assign src_ready = (state == S_IDLE);
  assign src_acc   = src_valid && src_ready;

  // output register may take a word when empty or being drained
  assign out_load = (state == S_ACC) && gain_ph && (!dst_valid || dst_ready);

  // Q1.23 -> Q9.31
  assign x_scaled = {{(HIST_W-SAMPLE_W-8){sample_in[SAMPLE_W-1]}}, sample_in, 8'b0};

  // history memory: reads happen only in the read state, writes only in write-back,
  // so an access never overlaps another to the same entry
  assign rd_en   = (state == S_READ);
  assign rd_addr = ADDR_W'({sec, term});

  // write-back order: x2 <- x1, x1 <- x, y2 <- y1, y1 <- y
  always_comb begin
    case (wcnt)
      2'd0: begin
        wterm   = TERM_X2;
        wr_data = x1_save;
      end
      2'd1: begin
        wterm   = TERM_X1;
        wr_data = x_cur;
      end
      2'd2: begin
        wterm   = TERM_Y2;
        wr_data = y1_save;
      end
      default: begin
        wterm   = TERM_Y1;
        wr_data = y_val;
      end
    endcase
  end

  assign wr_en   = (state == S_WB);
  assign wr_addr = ADDR_W'({sec, wterm});

  dcbq_hist_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // shared multiplier and rounding
  assign mac_ctl.mul_lo = (state == S_MLO);
  assign mac_ctl.mul_hi = (state == S_MHI);
  assign mac_ctl.gain   = gain_ph;
  assign coef = gain_ph ? GAIN_Q30 : coef_lookup(2'(sec), term);

  dcbq_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .coef    (coef),
    .h       (h_reg),
    .rounded (rounded)
  );

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sec     <= '0;
      term    <= TERM_X1;
      wcnt    <= '0;
      gain_ph <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (src_acc) begin
            state   <= S_READ;
            sec     <= '0;
            term    <= TERM_X1;
            gain_ph <= 1'b0;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_ACC;
        S_ACC: begin
          if (gain_ph) begin
            if (out_load) begin
              state   <= S_IDLE;
              gain_ph <= 1'b0;
            end
          end else if (term == TERM_Y2) begin
            state <= S_SAT;
          end else begin
            term  <= term + 2'd1;
            state <= S_READ;
          end
        end
        S_SAT: begin
          state <= S_WB;
          wcnt  <= '0;
        end
        S_WB: begin
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd3) begin
            if (sec == SEC_W'(SECTIONS - 1)) begin
              state <= S_GAIN;
            end else begin
              sec   <= sec + SEC_W'(1);
              term  <= TERM_X1;
              state <= S_READ;
            end
          end
        end
        S_GAIN: begin
          gain_ph <= 1'b1;
          state   <= S_MLO;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (src_acc) begin
          x_cur <= x_scaled;
          acc   <= ACC_W'(x_scaled);
        end
      end
      S_LOAD: begin
        h_reg <= rd_data;
        if (term == TERM_X1) begin
          x1_save <= rd_data;
        end
        if (term == TERM_Y1) begin
          y1_save <= rd_data;
        end
      end
      S_ACC: begin
        if (!gain_ph) begin
          // feedforward terms add, feedback terms subtract
          if (term == TERM_X1 || term == TERM_X2) begin
            acc <= acc + rounded;
          end else begin
            acc <= acc - rounded;
          end
        end
      end
      S_SAT: begin
        if (acc > ACC_W'(HIST_MAX)) begin
          y_val <= HIST_MAX;
        end else if (acc < ACC_W'(HIST_MIN)) begin
          y_val <= HIST_MIN;
        end else begin
          y_val <= HIST_W'(acc);
        end
      end
      S_WB: begin
        if (wcnt == 2'd3) begin
          x_cur <= y_val;
          acc   <= ACC_W'(y_val);
        end
      end
      S_GAIN: begin
        // near-zero flush before the gain
        if (x_cur > -FLUSH_LIM && x_cur < FLUSH_LIM) begin
          h_reg <= '0;
        end else begin
          h_reg <= x_cur;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_load) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rounded > ACC_W'(SMP_MAX)) begin
        sample_out <= SMP_MAX;
      end else if (rounded < ACC_W'(SMP_MIN)) begin
        sample_out <= SMP_MIN;
      end else begin
        sample_out <= SAMPLE_W'(rounded);
      end
    end
  end

  // an accepted word starts at the first history slot of the first section
  `DCBQ_ASSERT_NEXT(a_start, clk, rst, src_acc, state == S_READ && sec == '0 && term == TERM_X1)
  // history memory never reads and writes in the same cycle
  `DCBQ_ASSERT_NOW(a_no_overlap, clk, rst, rd_en, !wr_en)
  // a finished word always lands in the output register
  `DCBQ_ASSERT_NEXT(a_deliver, clk, rst, out_load, dst_valid && state == S_IDLE)

endmodule
